// File: sv/assert_macros.svh
// Assertion macros shared by the dimmer RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define MPCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define MPCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mpcd_pkg.sv
`timescale 1ns / 1ps

package mpcd_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int ACTION_W = 2;
    localparam int CHAN_W   = 5;
    localparam int LEVEL_W  = 7;
    localparam int DRIVE_W  = 17;

    // Default configuration of the block.
    localparam int CHANNELS_DEF  = 17;
    localparam int LEVEL_MAX_DEF = 100;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK       = 2'd0,
        ACT_ZERO_CROSS = 2'd1,
        ACT_WRITE      = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

endpackage

// File: sv/multichannel_phase_cut_dimmer_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  action, channel, level
// output    out        out_valid / out_stall drive
//
// A timer tick or a zero-cross transaction holds off the next acceptance until its
// channel sweep has run and its drive word is in the output register; the sweep
// reads one channel's levels from the level memories and decides it in the shared
// compare unit each cycle. A level write, or an unused action code, needs no sweep.
// Reset is asynchronous and active low; it clears the phase step, all drive bits
// and the level memories' valid bits, so that every level reads as zero.
// A stalled output holds its transaction in the output register. The input is stalled
// while a sweep runs or waits to report, or while that register is full and stalled.

module multichannel_phase_cut_dimmer_top #(
    parameter int CHANNELS  = mpcd_pkg::CHANNELS_DEF,
    parameter int LEVEL_MAX = mpcd_pkg::LEVEL_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mpcd_pkg::ACTION_W-1:0] action,
    input  logic [mpcd_pkg::CHAN_W-1:0]   channel,
    input  logic [mpcd_pkg::LEVEL_W-1:0]  level,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mpcd_pkg::DRIVE_W-1:0]  drive
);

    import mpcd_pkg::*;

    // Address width of the per-channel level memories and width of a stored level.
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LW = $clog2(LEVEL_MAX + 1);

    logic          pend_wr_en;
    logic [AW-1:0] pend_wr_addr;
    logic [LW-1:0] pend_wr_data;
    logic          act_wr_en;
    logic [AW-1:0] act_wr_addr;
    logic [LW-1:0] act_wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [LW-1:0] pend_rd_data;
    logic [LW-1:0] act_rd_data;

    // The sequencer owns the phase step, the drive bits and both handshakes.
    mpcd_ctrl #(
        .CHANNELS  (CHANNELS),
        .LEVEL_MAX (LEVEL_MAX),
        .AW        (AW),
        .LW        (LW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .channel      (channel),
        .level        (level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drive        (drive),
        .pend_wr_en   (pend_wr_en),
        .pend_wr_addr (pend_wr_addr),
        .pend_wr_data (pend_wr_data),
        .act_wr_en    (act_wr_en),
        .act_wr_addr  (act_wr_addr),
        .act_wr_data  (act_wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .pend_rd_data (pend_rd_data),
        .act_rd_data  (act_rd_data)
    );

    // Pending levels, written by level-write transactions.
    mpcd_level_ram #(
        .DEPTH (CHANNELS),
        .AW    (AW),
        .DW    (LW)
    ) u_pend_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (pend_wr_en),
        .wr_addr (pend_wr_addr),
        .wr_data (pend_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (pend_rd_data)
    );

    // Active levels, loaded from the pending levels during a sweep.
    mpcd_level_ram #(
        .DEPTH (CHANNELS),
        .AW    (AW),
        .DW    (LW)
    ) u_act_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (act_wr_en),
        .wr_addr (act_wr_addr),
        .wr_data (act_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (act_rd_data)
    );

endmodule

// File: sv/mpcd_level_ram.sv
`timescale 1ns / 1ps

module mpcd_level_ram #(
    parameter int DEPTH = mpcd_pkg::CHANNELS_DEF,
    parameter int AW    = 5,
    parameter int DW    = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    import mpcd_pkg::*;

    // Entries that have never been written since reset read as zero.
    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DW-1:0]    rdata_reg;
    logic             rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

// File: sv/mpcd_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mpcd_ctrl #(
    parameter int CHANNELS  = mpcd_pkg::CHANNELS_DEF,
    parameter int LEVEL_MAX = mpcd_pkg::LEVEL_MAX_DEF,
    parameter int AW        = 5,
    parameter int LW        = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [mpcd_pkg::ACTION_W-1:0] action,
    input  logic [mpcd_pkg::CHAN_W-1:0]   channel,
    input  logic [mpcd_pkg::LEVEL_W-1:0]  level,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [mpcd_pkg::DRIVE_W-1:0]  drive,
    output logic                         pend_wr_en,
    output logic [AW-1:0]                pend_wr_addr,
    output logic [LW-1:0]                pend_wr_data,
    output logic                         act_wr_en,
    output logic [AW-1:0]                act_wr_addr,
    output logic [LW-1:0]                act_wr_data,
    output logic                         rd_en,
    output logic [AW-1:0]                rd_addr,
    input  logic [LW-1:0]                pend_rd_data,
    input  logic [LW-1:0]                act_rd_data
);

    import mpcd_pkg::*;

    localparam int CW         = $clog2(CHANNELS + 1);
    localparam int SAT_W      = LEVEL_W + 1;
    localparam int CHAN_CMP_W = CHAN_W + 2;

    state_t            state_reg,     state_next;
    logic [CW-1:0]     cnt_reg,       cnt_next;
    logic [LW-1:0]     step_reg,      step_next;
    logic              is_zc_reg,     is_zc_next;
    logic              proc_valid_reg, proc_valid_next;
    logic [AW-1:0]     proc_idx_reg,  proc_idx_next;
    logic [CHANNELS-1:0] drive_reg,   drive_next;
    logic              out_valid_reg, out_valid_next;
    logic [DRIVE_W-1:0] drive_out_reg, drive_out_next;

    logic               accept;
    logic               out_free;
    logic               period_end;
    logic               sweep_more;
    logic [SAT_W-1:0]   level_ext;
    logic [DRIVE_W-1:0] drive_pack;

    // Only the low channels appear on the drive port.
    for (genvar b = 0; b < DRIVE_W; b++)
    begin : g_pack
        if (b < CHANNELS)
        begin : g_on
            assign drive_pack[b] = drive_reg[b];
        end
        else
        begin : g_off
            assign drive_pack[b] = 1'b0;
        end
    end

    assign in_stall   = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign period_end = step_reg >= LW'(LEVEL_MAX);
    assign sweep_more = cnt_reg < CW'(CHANNELS);
    assign level_ext  = {1'b0, level};

    assign pend_wr_addr = AW'(channel);
    assign pend_wr_data = (level_ext > SAT_W'(LEVEL_MAX)) ? LW'(LEVEL_MAX) : LW'(level_ext);
    assign act_wr_addr  = proc_idx_reg;
    assign rd_addr      = cnt_reg[AW-1:0];

    assign out_valid = out_valid_reg;
    assign drive     = drive_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            step_reg       <= '0;
            is_zc_reg      <= 1'b0;
            proc_valid_reg <= 1'b0;
            drive_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            step_reg       <= step_next;
            is_zc_reg      <= is_zc_next;
            proc_valid_reg <= proc_valid_next;
            drive_reg      <= drive_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg  <= proc_idx_next;
        drive_out_reg <= drive_out_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        step_next       = step_reg;
        is_zc_next      = is_zc_reg;
        proc_valid_next = 1'b0;
        proc_idx_next   = proc_idx_reg;
        drive_next      = drive_reg;
        out_valid_next  = out_valid_reg;
        drive_out_next  = drive_out_reg;
        pend_wr_en      = 1'b0;
        act_wr_en       = 1'b0;
        act_wr_data     = pend_rd_data;
        rd_en           = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        ACT_TICK:
                        begin
                            is_zc_next = 1'b0;
                            cnt_next   = '0;
                            state_next = ST_SWEEP;
                        end
                        ACT_ZERO_CROSS:
                        begin
                            is_zc_next = 1'b1;
                            step_next  = '0;
                            cnt_next   = '0;
                            state_next = ST_SWEEP;
                        end
                        ACT_WRITE:
                        begin
                            pend_wr_en     = CHAN_CMP_W'(channel) < CHAN_CMP_W'(CHANNELS);
                            out_valid_next = 1'b1;
                            drive_out_next = drive_pack;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            drive_out_next = drive_pack;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                // Read channel cnt while the channel before it is decided.
                rd_en           = sweep_more;
                proc_valid_next = sweep_more;
                proc_idx_next   = cnt_reg[AW-1:0];
                cnt_next        = cnt_reg + CW'(1);
                if (!sweep_more)
                begin
                    state_next = ST_FINISH;
                    if (!is_zc_reg)
                    begin
                        step_next = period_end ? '0 : step_reg + LW'(1);
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    drive_out_next = drive_pack;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Shared compare unit: one channel is decided each cycle.
        if (proc_valid_reg)
        begin
            if (is_zc_reg)
            begin
                act_wr_en = 1'b1;
            end
            else if ((pend_rd_data != '0) || (act_rd_data != '0))
            begin
                priority if (step_reg == act_rd_data)
                begin
                    drive_next[proc_idx_reg] = 1'b0;
                end
                else if (step_reg == '0)
                begin
                    drive_next[proc_idx_reg] = 1'b1;
                end
                else if (period_end)
                begin
                    act_wr_en = 1'b1;
                end
            end
        end
    end

    `MPCD_ASSERT(a_step_range, step_reg <= LW'(LEVEL_MAX), "phase step beyond maximum level")
    `MPCD_ASSERT_NEXT(a_step_held, (state_reg == ST_SWEEP) && sweep_more, $stable(step_reg), "phase step moved during a channel sweep")
    `MPCD_ASSERT_NEXT(a_zc_clears, accept && (action == ACT_ZERO_CROSS), step_reg == '0, "zero-cross did not clear the phase step")
    `MPCD_ASSERT_NEXT(a_drive_quiet, !proc_valid_reg, $stable(drive_reg), "drive changed outside channel processing")
    `MPCD_ASSERT(a_proc_in_sweep, !proc_valid_reg || (state_reg == ST_SWEEP), "channel processed outside a sweep")

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    import mpcd_pkg::*;

    localparam int NUM_CH      = CHANNELS_DEF;
    localparam int MAX_LEVEL   = LEVEL_MAX_DEF;
    localparam int ITEM_TARGET = 1450;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 30;

    // The block leaves action code 3 unused; it must report the drive and change nothing.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CHAN_W-1:0]   channel;
        logic [LEVEL_W-1:0]  level;
    } dimmer_item_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [ACTION_W-1:0] action    = ACT_TICK;
    logic [CHAN_W-1:0]   channel   = '0;
    logic [LEVEL_W-1:0]  level     = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [DRIVE_W-1:0]  drive;

    // Transactions waiting to be offered, and drive words still owed by the block.
    dimmer_item_t       dimmer_item_q[$];
    logic [DRIVE_W-1:0] drive_expect_q[$];
    dimmer_item_t       next_item;
    logic [DRIVE_W-1:0] drive_expected;

    int total_items  = 0;
    int taken_cnt    = 0;
    int mismatch_cnt = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    // Shadow copy of the dimmer state, advanced once per accepted transaction.
    logic [LEVEL_W-1:0] step_shadow;
    logic [LEVEL_W-1:0] pending_shadow[NUM_CH];
    logic [LEVEL_W-1:0] active_shadow[NUM_CH];
    logic [NUM_CH-1:0]  drive_shadow;

    multichannel_phase_cut_dimmer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .channel   (channel),
        .level     (level),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive)
    );

    always #10 clk = ~clk;

    // Applies one transaction to the shadow state and returns the drive word the block
    // should report for it.
    function automatic logic [DRIVE_W-1:0] dimmer_predict(input dimmer_item_t it);
        logic               period_end;
        logic [DRIVE_W-1:0] packed_drive;
        packed_drive = '0;
        if (it.action == ACT_TICK)
        begin
            period_end = (step_shadow >= MAX_LEVEL);
            for (int c = 0; c < NUM_CH; c++)
            begin
                // A channel with both levels at zero is left exactly as it is.
                if (pending_shadow[c] != 0 || active_shadow[c] != 0)
                begin
                    if (step_shadow == active_shadow[c])
                        drive_shadow[c] = 1'b0;
                    else if (step_shadow == 0)
                        drive_shadow[c] = 1'b1;
                    else if (period_end)
                        active_shadow[c] = pending_shadow[c];
                end
            end
            step_shadow = period_end ? '0 : step_shadow + 1'b1;
        end
        else if (it.action == ACT_ZERO_CROSS)
        begin
            step_shadow = '0;
            for (int c = 0; c < NUM_CH; c++)
                active_shadow[c] = pending_shadow[c];
        end
        else if (it.action == ACT_WRITE)
        begin
            // Writes beyond the last channel are dropped; levels saturate at the maximum.
            if (it.channel < NUM_CH)
                pending_shadow[it.channel] = (it.level > MAX_LEVEL) ? MAX_LEVEL[LEVEL_W-1:0]
                                                                    : it.level;
        end
        for (int c = 0; c < NUM_CH && c < DRIVE_W; c++)
            packed_drive[c] = drive_shadow[c];
        return packed_drive;
    endfunction

    // The run is split in thirds by accepted transactions: a slow receiver, then a
    // slow sender, then full speed on both sides.
    function automatic int idle_phase(input int accepted);
        if (accepted < total_items / 3)
            return 0;
        else if (accepted < (2 * total_items) / 3)
            return 1;
        return 2;
    endfunction

    task automatic queue_item(input logic [ACTION_W-1:0] act, input int unsigned chan,
                              input int unsigned lvl);
        dimmer_item_t it;
        it.action  = act;
        it.channel = chan[CHAN_W-1:0];
        it.level   = lvl[LEVEL_W-1:0];
        dimmer_item_q.push_back(it);
    endtask

    // Mostly in-range levels, with an occasional one above the maximum.
    function automatic int unsigned pick_level();
        if ($urandom_range(7) == 0)
            return $urandom_range(127, MAX_LEVEL + 1);
        return $urandom_range(MAX_LEVEL);
    endfunction

    // Driver: records the prediction for each accepted transaction and offers the next
    // one, idling at random but never withdrawing a transaction once offered.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action   <= ACT_TICK;
            channel  <= '0;
            level    <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                next_item.action  = action;
                next_item.channel = channel;
                next_item.level   = level;
                drive_expect_q.push_back(dimmer_predict(next_item));
                taken_cnt <= taken_cnt + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (dimmer_item_q.size() != 0 &&
                    $urandom_range(99) >= (idle_phase(taken_cnt) == 0 ? 13 :
                                           idle_phase(taken_cnt) == 1 ? 80 : 0))
                begin
                    next_item = dimmer_item_q.pop_front();
                    in_valid <= 1'b1;
                    action   <= next_item.action;
                    channel  <= next_item.channel;
                    level    <= next_item.level;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted drive transaction against the oldest prediction and
    // drives the receiver's stall, including one long hold-off at the start of the
    // full-speed third so that the output register and then the input back up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (drive_expect_q.size() == 0)
                begin
                    $error("drive: unexpected transaction, actual 0x%05h", drive);
                    mismatch_cnt++;
                end
                else
                begin
                    drive_expected = drive_expect_q.pop_front();
                    if (drive !== drive_expected)
                    begin
                        $error("drive: expected 0x%05h, actual 0x%05h", drive_expected, drive);
                        mismatch_cnt++;
                    end
                end
            end
            if (!hold_done && idle_phase(taken_cnt) == 2)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < (idle_phase(taken_cnt) == 0 ? 80 :
                                                    idle_phase(taken_cnt) == 1 ? 13 : 0));
            end
        end
    end

    initial
    begin
        int unsigned run_len;

        step_shadow  = '0;
        drive_shadow = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            pending_shadow[c] = '0;
            active_shadow[c]  = '0;
        end

        // Directed opening: a tick with everything idle, saturation, dropped writes,
        // the unused code, and a channel that goes idle while its output is high.
        queue_item(ACT_TICK, 0, 0);
        queue_item(ACT_ZERO_CROSS, 0, 0);
        queue_item(ACT_WRITE, 0, 0);
        queue_item(ACT_WRITE, NUM_CH - 1, 127);
        queue_item(ACT_WRITE, 31, 50);
        queue_item(ACT_WRITE, NUM_CH, 1);
        queue_item(ACT_WRITE, 5, 1);
        queue_item(ACT_WRITE, 3, 2);
        queue_item(ACT_WRITE, 10, 64);
        queue_item(ACT_WRITE, 7, 3);
        queue_item(ACT_UNUSED, 31, 127);
        queue_item(ACT_ZERO_CROSS, 0, 0);
        queue_item(ACT_TICK, 0, 0);
        queue_item(ACT_WRITE, 7, 0);
        queue_item(ACT_ZERO_CROSS, 31, 127);
        queue_item(ACT_TICK, 31, 127);
        queue_item(ACT_TICK, 0, 0);
        queue_item(ACT_TICK, 0, 0);
        queue_item(ACT_TICK, 0, 0);
        queue_item(ACT_WRITE, 21, 42);
        queue_item(ACT_WRITE, 14, MAX_LEVEL - 15);
        queue_item(ACT_ZERO_CROSS, 0, 0);
        queue_item(ACT_TICK, 0, 0);
        queue_item(ACT_UNUSED, 0, 0);

        // Random part. Most of it is mains half-cycles: a zero-cross, a few level writes,
        // then a run of ticks that is sometimes long enough to wrap the phase step.
        // The rest is unstructured noise over the whole field ranges.
        while (dimmer_item_q.size() < ITEM_TARGET)
        begin
            if ($urandom_range(9) < 8)
            begin
                queue_item(ACT_ZERO_CROSS, $urandom_range(31), $urandom_range(127));
                repeat ($urandom_range(3))
                    queue_item(ACT_WRITE, $urandom_range(NUM_CH - 1), pick_level());
                run_len = $urandom_range(130, 5);
                repeat (run_len)
                begin
                    if ($urandom_range(19) == 0)
                        queue_item(ACT_WRITE, $urandom_range(NUM_CH - 1), pick_level());
                    else
                        queue_item(ACT_TICK, $urandom_range(31), $urandom_range(127));
                end
            end
            else
            begin
                repeat ($urandom_range(8, 1))
                    queue_item(ACTION_W'($urandom_range(3)), $urandom_range(31),
                               $urandom_range(127));
            end
        end
        total_items = dimmer_item_q.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (taken_cnt < total_items || drive_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legitimate run.
    initial
    begin
        #20_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
